FILE: rtl/core/prm_pkg.sv
`timescale 1ns / 1ps
// prm_pkg: command, alarm and register index codes for the pump runtime alarm monitor
// no dependencies

package prm_pkg;

    // command codes carried on the input tuser
    localparam logic [1:0] CMD_UPDATE = 2'd0;
    localparam logic [1:0] CMD_CLOSE  = 2'd1;
    localparam logic [1:0] CMD_START  = 2'd2;

    // alarm codes
    localparam logic [1:0] ALM_NONE      = 2'd0;
    localparam logic [1:0] ALM_LONG_ON   = 2'd1;
    localparam logic [1:0] ALM_SHORT_OFF = 2'd2;
    localparam logic [1:0] ALM_LONG_OFF  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_ON_TIME_LIMIT   = 2'd0;
    localparam logic [1:0] REG_SHORT_OFF_LIMIT = 2'd1;
    localparam logic [1:0] REG_OFF_TIME_LIMIT  = 2'd2;

    localparam int CFG_BITS = 32;
    localparam int OUT_BITS = 32;

    // reset values of the limits
    localparam logic [CFG_BITS-1:0] ON_TIME_LIMIT_RST   = 32'd600;
    localparam logic [CFG_BITS-1:0] SHORT_OFF_LIMIT_RST = 32'd60;
    localparam logic [CFG_BITS-1:0] OFF_TIME_LIMIT_RST  = 32'd86400;

    // result packing: alarm, pump_on, five 32-bit counts
    localparam int RES_BITS  = 2 + 1 + 5 * OUT_BITS;
    localparam int RES_TBITS = ((RES_BITS + 7) / 8) * 8;

endpackage

FILE: rtl/core/pump_runtime_alarm_monitor_top.sv
`timescale 1ns / 1ps
// pump_runtime_alarm_monitor_top: stream wrapper, limit registers, input and result registers
// depends on prm_pkg and prm_core

// Pump runtime alarm monitor. Each input item carries a command on tuser
// (update, close period, start) and the seconds count and converter sample
// on tdata; every item yields exactly one result item with the alarm code,
// pump state, time in the current state, the last on and off intervals and
// the open and closed period on totals, all taken after the item is applied.
// A sample above half scale counts as running. The block takes one item per
// clock while the sink does not stall: an item is captured in the input
// register, its update runs through the state logic of prm_core and lands in
// the result register, from which it is offered to the sink. The state
// registers are read and written in the same cycle, which is what sets the
// rate at one item per clock. The result register holds while the sink
// stalls and the input register still takes one more item meanwhile. The
// three 32-bit limits are written through the plain configuration port
// (index 0 on-time limit, 1 short-off limit, 2 off-time limit); the user
// must write them while no item is in flight, which the block does not
// enforce; other indexes are ignored.

module pump_runtime_alarm_monitor_top
    import prm_pkg::*;
#(
    parameter int TIME_BITS   = 32,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_wr_en,
    input  logic [1:0]           i_cfg_index,
    input  logic [CFG_BITS-1:0]  i_cfg_wdata,
    // input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata from bit 0: now_seconds, level_sample, zero pad
    input  logic [(((TIME_BITS + SAMPLE_BITS) + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: command
    input  logic [1:0]           s_axis_tuser,
    // result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata from bit 0: alarm_code, pump_on, state_duration, last_on_time,
    // last_off_time, period_on_total, closed_period_total, zero pad
    output logic [RES_TBITS-1:0] m_axis_tdata
);

    // limit registers
    logic [CFG_BITS-1:0] r_on_time_limit;
    logic [CFG_BITS-1:0] r_short_off_limit;
    logic [CFG_BITS-1:0] r_off_time_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_time_limit   <= ON_TIME_LIMIT_RST;
            r_short_off_limit <= SHORT_OFF_LIMIT_RST;
            r_off_time_limit  <= OFF_TIME_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_ON_TIME_LIMIT:   r_on_time_limit   <= i_cfg_wdata;
                REG_SHORT_OFF_LIMIT: r_short_off_limit <= i_cfg_wdata;
                REG_OFF_TIME_LIMIT:  r_off_time_limit  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input register
    logic                   r_in_valid;
    logic [1:0]             r_in_cmd;
    logic [TIME_BITS-1:0]   r_in_now;
    logic [SAMPLE_BITS-1:0] r_in_smp;

    // result register
    logic                r_out_valid;
    logic [1:0]          r_out_alarm;
    logic                r_out_pump_on;
    logic [OUT_BITS-1:0] r_out_duration;
    logic [OUT_BITS-1:0] r_out_on_time;
    logic [OUT_BITS-1:0] r_out_off_time;
    logic [OUT_BITS-1:0] r_out_psum;
    logic [OUT_BITS-1:0] r_out_closed;

    logic                advance;
    logic                in_take;
    logic [1:0]          res_alarm;
    logic                res_pump_on;
    logic [OUT_BITS-1:0] res_duration;
    logic [OUT_BITS-1:0] res_on_time;
    logic [OUT_BITS-1:0] res_off_time;
    logic [OUT_BITS-1:0] res_psum;
    logic [OUT_BITS-1:0] res_closed;

    // the held item moves on when the result register is free or being emptied
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_cmd <= s_axis_tuser;
            r_in_now <= s_axis_tdata[TIME_BITS-1:0];
            r_in_smp <= s_axis_tdata[TIME_BITS +: SAMPLE_BITS];
        end
    end

    prm_core #(
        .TIME_BITS   (TIME_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_en                  (advance),
        .i_command             (r_in_cmd),
        .i_now                 (r_in_now),
        .i_sample              (r_in_smp),
        .i_on_time_limit       (r_on_time_limit),
        .i_short_off_limit     (r_short_off_limit),
        .i_off_time_limit      (r_off_time_limit),
        .o_alarm_code          (res_alarm),
        .o_pump_on             (res_pump_on),
        .o_state_duration      (res_duration),
        .o_last_on_time        (res_on_time),
        .o_last_off_time       (res_off_time),
        .o_period_on_total     (res_psum),
        .o_closed_period_total (res_closed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_alarm    <= res_alarm;
            r_out_pump_on  <= res_pump_on;
            r_out_duration <= res_duration;
            r_out_on_time  <= res_on_time;
            r_out_off_time <= res_off_time;
            r_out_psum     <= res_psum;
            r_out_closed   <= res_closed;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = RES_TBITS'({r_out_closed, r_out_psum, r_out_off_time,
                                       r_out_on_time, r_out_duration,
                                       r_out_pump_on, r_out_alarm});

endmodule

FILE: rtl/core/prm_core.sv
`timescale 1ns / 1ps
// prm_core: pump state registers and the per-item update logic
// depends on prm_pkg

module prm_core
    import prm_pkg::*;
#(
    parameter int TIME_BITS   = 32,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [1:0]             i_command,
    input  logic [TIME_BITS-1:0]   i_now,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [CFG_BITS-1:0]    i_on_time_limit,
    input  logic [CFG_BITS-1:0]    i_short_off_limit,
    input  logic [CFG_BITS-1:0]    i_off_time_limit,
    output logic [1:0]             o_alarm_code,
    output logic                   o_pump_on,
    output logic [OUT_BITS-1:0]    o_state_duration,
    output logic [OUT_BITS-1:0]    o_last_on_time,
    output logic [OUT_BITS-1:0]    o_last_off_time,
    output logic [OUT_BITS-1:0]    o_period_on_total,
    output logic [OUT_BITS-1:0]    o_closed_period_total
);

    // compare width covers both the time counts and the 32-bit limits
    localparam int CMP_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
    localparam logic [SAMPLE_BITS-1:0] HALF_SCALE = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

    logic                 r_running,  n_running;
    logic [TIME_BITS-1:0] r_change,   n_change;
    logic [TIME_BITS-1:0] r_pstart,   n_pstart;
    logic [TIME_BITS-1:0] r_on_int,   n_on_int;
    logic [TIME_BITS-1:0] r_off_int,  n_off_int;
    logic [TIME_BITS-1:0] r_psum,     n_psum;
    logic [TIME_BITS-1:0] r_prev_sum, n_prev_sum;
    logic [1:0]           r_alarm,    n_alarm;

    logic                 high;
    logic [TIME_BITS-1:0] held;
    logic [TIME_BITS-1:0] since_pstart;
    logic [TIME_BITS-1:0] on_in_period;

    assign high         = i_sample > HALF_SCALE;
    assign held         = i_now - r_change;
    assign since_pstart = i_now - r_pstart;
    // only the part of the on interval inside the current period counts
    assign on_in_period = (r_change > r_pstart) ? held : since_pstart;

    always_comb begin
        n_running  = r_running;
        n_change   = r_change;
        n_pstart   = r_pstart;
        n_on_int   = r_on_int;
        n_off_int  = r_off_int;
        n_psum     = r_psum;
        n_prev_sum = r_prev_sum;
        n_alarm    = r_alarm;
        unique case (i_command)
            CMD_START: begin
                n_change   = i_now;
                n_pstart   = i_now;
                n_on_int   = '0;
                n_off_int  = '0;
                n_psum     = '0;
                n_prev_sum = '0;
                n_running  = high;
                n_alarm    = ALM_NONE;
            end
            CMD_CLOSE: begin
                n_prev_sum = r_psum;
                n_pstart   = i_now;
                n_psum     = '0;
            end
            CMD_UPDATE: begin
                if (high) begin
                    if (!r_running) begin
                        // off-to-on edge
                        n_off_int = held;
                        n_change  = i_now;
                        n_running = 1'b1;
                        if (CMP_BITS'(held) <= CMP_BITS'(i_short_off_limit)) begin
                            n_alarm = ALM_SHORT_OFF;
                        end
                    end else begin
                        n_alarm = (CMP_BITS'(held) > CMP_BITS'(i_on_time_limit))
                                  ? ALM_LONG_ON : ALM_NONE;
                    end
                end else begin
                    if (r_running) begin
                        // on-to-off edge
                        n_on_int  = held;
                        n_psum    = r_psum + on_in_period;
                        n_change  = i_now;
                        n_running = 1'b0;
                    end else begin
                        n_alarm = (CMP_BITS'(held) > CMP_BITS'(i_off_time_limit))
                                  ? ALM_LONG_OFF : ALM_NONE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= 1'b0;
            r_change   <= '0;
            r_pstart   <= '0;
            r_on_int   <= '0;
            r_off_int  <= '0;
            r_psum     <= '0;
            r_prev_sum <= '0;
            r_alarm    <= ALM_NONE;
        end else if (i_en) begin
            r_running  <= n_running;
            r_change   <= n_change;
            r_pstart   <= n_pstart;
            r_on_int   <= n_on_int;
            r_off_int  <= n_off_int;
            r_psum     <= n_psum;
            r_prev_sum <= n_prev_sum;
            r_alarm    <= n_alarm;
        end
    end

    // result reflects the state after this item
    assign o_alarm_code          = n_alarm;
    assign o_pump_on             = n_running;
    assign o_state_duration      = OUT_BITS'(i_now - n_change);
    assign o_last_on_time        = OUT_BITS'(n_on_int);
    assign o_last_off_time       = OUT_BITS'(n_off_int);
    assign o_period_on_total     = OUT_BITS'(n_psum);
    assign o_closed_period_total = OUT_BITS'(n_prev_sum);

endmodule

FILE: rtl/core/prm_checker.sv
`timescale 1ns / 1ps
// prm_checker: port-level assertions for the pump runtime alarm monitor, with its bind
// depends on pump_runtime_alarm_monitor_top

module prm_checker #(
    parameter int OUT_TBITS = 168
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [OUT_TBITS-1:0] m_axis_tdata
);

    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with no result pending");

    // an accepted item passes the input register and reaches the output when the sink is ready
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("accepted item did not produce a result");

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its data
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

endmodule

bind pump_runtime_alarm_monitor_top prm_checker #(
    .OUT_TBITS (prm_pkg::RES_TBITS)
) u_prm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
